[rtl/core/dsr_pkg.sv]
// ----------------------------------------------------------------------------
// Disk request scheduler package
// Request, response and queue entry types, policy codes and the control
// bundle between the sequencer and the selection unit.
// ----------------------------------------------------------------------------
package dsr_pkg;

   localparam logic [1:0] POLICY_FCFS = 2'd0;
   localparam logic [1:0] POLICY_SSTF = 2'd1;
   localparam logic [1:0] POLICY_LOOK = 2'd2;

   localparam logic MODE_ARRIVAL  = 1'b0;
   localparam logic MODE_COMPLETE = 1'b1;

   // LOOK candidate classes, lower wins.
   localparam logic [1:0] CLASS_SAME  = 2'd0;
   localparam logic [1:0] CLASS_AHEAD = 2'd1;
   localparam logic [1:0] CLASS_OTHER = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [15:0] xfer_id;
      logic [15:0] source_id;
      logic [31:0] arrival_time;
      logic [15:0] cylinder;
      logic [31:0] address;
      logic [15:0] head_cylinder;
      logic        scan_up;
   } req_type;

   typedef struct packed {
      logic        served_valid;
      logic [15:0] served_xfer_id;
      logic [15:0] served_source_id;
      logic [31:0] served_arrival_time;
      logic [15:0] served_cylinder;
      logic [31:0] served_address;
      logic        dropped;
      logic [4:0]  pending_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] xfer_id;
      logic [15:0] source_id;
      logic [31:0] arrival_time;
      logic [15:0] cylinder;
      logic [31:0] address;
   } entry_type;

   // Selection key: class, primary value, secondary value; smaller wins.
   typedef struct packed {
      logic [1:0]  rank;
      logic [31:0] primary;
      logic [31:0] secondary;
   } key_type;

   typedef struct packed {
      logic cand_valid;
      logic cand_first;
   } sel_ctrl_type;

endpackage

[rtl/core/disk_request_scheduler.sv]
// ----------------------------------------------------------------------------
// Disk request scheduler
// Holds the request in service and a queue of pending requests, and picks
// the next request on a completion by FCFS, SSTF or LOOK.
// ----------------------------------------------------------------------------
// Each request produces exactly one response describing the request in
// service afterwards. An arrival passes from idle to the done state, which
// loads the response once the output register is free and then returns to
// idle for the next request. A completion with N requests queued reads the
// queue memory once per entry to find the best candidate, then streams the
// entries behind the chosen one down by one place through the same memory
// port (none move when the chosen entry is the last), and then the done
// state loads the response in the same way.
// The block takes no new request while one is being worked on; a finished
// response may wait in the output register while the next request is
// accepted. The policy register should be written only while idle.
// ----------------------------------------------------------------------------
module disk_request_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_write_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  dsr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dsr_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_MOVE,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         policy_ff, policy_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               busy_ff, busy_in;
   dsr_pkg::entry_type cur_ff, cur_in;
   logic               drop_ff, drop_in;
   logic [15:0]        head_ff, head_in;
   logic               up_ff, up_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic               data_vld_ff, data_vld_in;
   logic [IDX_W-1:0]   data_idx_ff, data_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dsr_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               accept;
   dsr_pkg::entry_type arrive_rec;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   dsr_pkg::entry_type ram_wr_data;
   logic               ram_rd_en;
   dsr_pkg::entry_type ram_rd_data;
   logic [IDX_W-1:0]   best_idx;
   dsr_pkg::entry_type best_rec;
   dsr_pkg::sel_ctrl_type sel_ctrl;
   logic               scan_last;

   dsr_ram #(
      .WIDTH ($bits(dsr_pkg::entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   dsr_select #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_select (
      .clock    (clock),
      .ctrl     (sel_ctrl),
      .policy   (policy_ff),
      .head     (head_ff),
      .scan_up  (up_ff),
      .cand     (ram_rd_data),
      .cand_idx (data_idx_ff),
      .best_idx (best_idx),
      .best_rec (best_rec)
   );

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;

      arrive_rec.xfer_id      = req_data.xfer_id;
      arrive_rec.source_id    = req_data.source_id;
      arrive_rec.arrival_time = req_data.arrival_time;
      arrive_rec.cylinder     = req_data.cylinder;
      arrive_rec.address      = req_data.address;

      // The read port walks the pointer during both the scan and the move.
      ram_rd_en = ((state_ff == ST_SCAN) || (state_ff == ST_MOVE)) && (ptr_ff < count_ff);

      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[IDX_W-1:0];
      ram_wr_data = arrive_rec;
      if (accept && (req_data.mode == dsr_pkg::MODE_ARRIVAL) && busy_ff
          && (count_ff < DEPTH_C)) begin
         ram_wr_en = 1'b1;
      end else if ((state_ff == ST_MOVE) && data_vld_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = data_idx_ff - IDX_W'(1);
         ram_wr_data = ram_rd_data;
      end

      sel_ctrl.cand_valid = (state_ff == ST_SCAN) && data_vld_ff;
      sel_ctrl.cand_first = (data_idx_ff == '0);
      scan_last = sel_ctrl.cand_valid && (CNT_W'(data_idx_ff) == (count_ff - CNT_W'(1)));

      state_in     = state_ff;
      policy_in    = csr_write_enable ? csr_write_data : policy_ff;
      count_in     = count_ff;
      busy_in      = busy_ff;
      cur_in       = cur_ff;
      drop_in      = drop_ff;
      head_in      = head_ff;
      up_in        = up_ff;
      ptr_in       = ram_rd_en ? (ptr_ff + CNT_W'(1)) : ptr_ff;
      data_vld_in  = ram_rd_en;
      data_idx_in  = ptr_ff[IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               drop_in  = 1'b0;
               state_in = ST_DONE;
               if (req_data.mode == dsr_pkg::MODE_ARRIVAL) begin
                  if (!busy_ff) begin
                     busy_in = 1'b1;
                     cur_in  = arrive_rec;
                  end else if (count_ff < DEPTH_C) begin
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     drop_in = 1'b1;
                  end
               end else if (count_ff == '0) begin
                  busy_in = 1'b0;
                  cur_in  = '0;
               end else begin
                  head_in  = req_data.head_cylinder;
                  up_in    = req_data.scan_up;
                  ptr_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            // Entries after the chosen one move down by one place.
            ptr_in   = CNT_W'(best_idx) + CNT_W'(1);
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            if (!ram_rd_en && !data_vld_ff) begin
               cur_in   = best_rec;
               busy_in  = 1'b1;
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                    = 1'b1;
               rsp_data_in.served_valid        = busy_ff;
               rsp_data_in.served_xfer_id      = cur_ff.xfer_id;
               rsp_data_in.served_source_id    = cur_ff.source_id;
               rsp_data_in.served_arrival_time = cur_ff.arrival_time;
               rsp_data_in.served_cylinder     = cur_ff.cylinder;
               rsp_data_in.served_address      = cur_ff.address;
               rsp_data_in.dropped             = drop_ff;
               rsp_data_in.pending_count       = 5'(count_ff);
               state_in                        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= dsr_pkg::POLICY_FCFS;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         cur_ff       <= '0;
         drop_ff      <= 1'b0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         cur_ff       <= cur_in;
         drop_ff      <= drop_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_ff     <= head_in;
      up_ff       <= up_in;
      ptr_ff      <= ptr_in;
      data_idx_ff <= data_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/dsr_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dsr_ram #(
   parameter int WIDTH = 112,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/dsr_select.sv]
// ----------------------------------------------------------------------------
// Disk request scheduler selection unit
// Builds a sort key for each queue entry as it streams past and keeps the
// best entry seen so far, using one shared key comparator.
// ----------------------------------------------------------------------------
module dsr_select #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  dsr_pkg::sel_ctrl_type         ctrl,
   input  logic [1:0]                    policy,
   input  logic [15:0]                   head,
   input  logic                          scan_up,
   input  dsr_pkg::entry_type            cand,
   input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] cand_idx,
   output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] best_idx,
   output dsr_pkg::entry_type            best_rec
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   dsr_pkg::key_type   key;
   dsr_pkg::key_type   best_key_ff;
   dsr_pkg::key_type   best_key_in;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [IDX_W-1:0]   best_idx_in;
   dsr_pkg::entry_type best_rec_ff;
   dsr_pkg::entry_type best_rec_in;
   logic [15:0]        seek_len;
   logic               ahead;
   logic               take;

   always_comb begin
      seek_len = (cand.cylinder >= head) ? (cand.cylinder - head) : (head - cand.cylinder);
      ahead    = scan_up ? (cand.cylinder > head) : (cand.cylinder < head);
      case (policy)
         dsr_pkg::POLICY_SSTF: begin
            key.rank      = dsr_pkg::CLASS_SAME;
            key.primary   = {16'd0, seek_len};
            key.secondary = cand.arrival_time;
         end
         dsr_pkg::POLICY_LOOK: begin
            key.secondary = 32'd0;
            if (cand.cylinder == head) begin
               key.rank    = dsr_pkg::CLASS_SAME;
               key.primary = cand.arrival_time;
            end else if (ahead) begin
               key.rank    = dsr_pkg::CLASS_AHEAD;
               key.primary = {16'd0, seek_len};
            end else begin
               key.rank    = dsr_pkg::CLASS_OTHER;
               key.primary = {16'd0, seek_len};
            end
         end
         default: begin
            key.rank      = dsr_pkg::CLASS_SAME;
            key.primary   = cand.arrival_time;
            key.secondary = 32'd0;
         end
      endcase

      // Strict compare keeps the earlier queue position on a tie.
      take = ctrl.cand_valid && (ctrl.cand_first || (key < best_key_ff));

      best_key_in = take ? key : best_key_ff;
      best_idx_in = take ? cand_idx : best_idx_ff;
      best_rec_in = take ? cand : best_rec_ff;
   end

   always_ff @(posedge clock) begin
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
      best_rec_ff <= best_rec_in;
   end

   assign best_idx = best_idx_ff;
   assign best_rec = best_rec_ff;

endmodule
